>>> hdl/pcce_pkg.sv
// pcce_pkg: shared types, constants and the crc-32 byte fold for the cksum engine
// no dependencies; imported by the interfaces, datapath, controller and top level
`default_nettype none

package pcce_pkg;

  // fixed field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 32;
  localparam int unsigned FILE_LEN_W = 48;

  // crc-32 generator, msb first, not reflected
  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;

  // commands from controller to datapath
  typedef struct packed {
    logic take;       // input beat accepted this cycle
    logic tail_step;  // fold one length byte and shift the tail
    logic emit;       // load the result register and clear for the next file
  } pcce_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic tail_zero;  // no length bytes left to fold
  } pcce_status_t;

  // fold one byte into the crc, one bit per step
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/pcce_if.sv
// pcce_if: valid/ready channel interfaces for the cksum engine input and result
// depends on pcce_pkg for field widths
`default_nettype none

interface pcce_in_if;
  import pcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              has_byte;
  logic              last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink   (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

interface pcce_out_if;
  import pcce_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CRC_W-1:0]      crc_value;
  logic [FILE_LEN_W-1:0] file_length;
  logic                  length_overflow;

  modport source (output valid, output crc_value, output file_length,
                  output length_overflow, input ready);
  modport sink   (input valid, input crc_value, input file_length,
                  input length_overflow, output ready);
endinterface

`default_nettype wire

>>> hdl/posix_cksum_crc32_engine_core.sv
// posix_cksum_crc32_engine_core: posix cksum (crc-32, length appended) over a byte stream
// depends on pcce_pkg, pcce_if, pcce_controller and pcce_datapath
//
//   channel | dir | beat fields                                  | ends when
//   in_i    | in  | data_byte, has_byte, last                    | valid && ready
//   out_o   | out | crc_value, file_length, length_overflow      | valid && ready
//
// one input beat per cycle while a file streams; beats with a byte fold it into the crc.
// after a last beat the count is folded one byte per cycle through the same crc unit,
// low byte first, until no nonzero byte is left; the result register loads once it is free.
// input ready is low for the whole tail; the result waits in its register, so a stalled
// output only holds the next file's tail, not its byte stream.
// asynchronous reset clears the crc, count, overflow flag, tail and result valid.
`default_nettype none

module posix_cksum_crc32_engine_core #(
  parameter int unsigned LENGTH_BITS = 48
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcce_in_if.sink    in_i,
  pcce_out_if.source out_o
);
  import pcce_pkg::*;

  pcce_cmd_t    cmd;
  pcce_status_t status;

  // sequencer
  pcce_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.last),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // crc, count and result register
  pcce_datapath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .data_byte_i       (in_i.data_byte),
    .has_byte_i        (in_i.has_byte),
    .last_i            (in_i.last),
    .crc_value_o       (out_o.crc_value),
    .file_length_o     (out_o.file_length),
    .length_overflow_o (out_o.length_overflow)
  );

endmodule

`default_nettype wire

>>> hdl/pcce_datapath.sv
// pcce_datapath: running crc, saturating byte count, length tail shifter and result register
// depends on pcce_pkg; driven by pcce_controller through pcce_cmd_t
`default_nettype none

module pcce_datapath #(
  parameter int unsigned LENGTH_BITS = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcce_pkg::pcce_cmd_t              cmd_i,
  output pcce_pkg::pcce_status_t           status_o,
  input  logic [pcce_pkg::BYTE_W-1:0]      data_byte_i,
  input  logic                             has_byte_i,
  input  logic                             last_i,
  output logic [pcce_pkg::CRC_W-1:0]       crc_value_o,
  output logic [pcce_pkg::FILE_LEN_W-1:0]  file_length_o,
  output logic                             length_overflow_o
);
  import pcce_pkg::*;

  logic [CRC_W-1:0]       crc_q, crc_d;
  logic [LENGTH_BITS-1:0] count_q, count_d;
  logic                   ovf_q, ovf_d;
  logic [LENGTH_BITS-1:0] tail_q, tail_d;

  logic [BYTE_W-1:0]      fold_byte;
  logic [CRC_W-1:0]       crc_fold;
  logic                   count_full;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [FILE_LEN_W-1:0]  len_ext;

  logic [CRC_W-1:0]       crc_out_q;
  logic [FILE_LEN_W-1:0]  len_out_q;
  logic                   ovf_out_q;

  // one shared byte fold: file byte while streaming, length byte during the tail
  assign fold_byte = cmd_i.tail_step ? tail_q[BYTE_W-1:0] : data_byte_i;
  assign crc_fold  = crc_byte(crc_q, fold_byte);

  // saturating count
  assign count_full = &count_q;
  assign count_inc  = count_full ? count_q : count_q + LENGTH_BITS'(1);

  // reported length, masked or zero-extended to the output width
  if (LENGTH_BITS >= FILE_LEN_W) begin : g_len_mask
    assign len_ext = count_q[FILE_LEN_W-1:0];
  end else begin : g_len_ext
    assign len_ext = {{(FILE_LEN_W-LENGTH_BITS){1'b0}}, count_q};
  end

  // next state of the running values
  always_comb begin
    crc_d   = crc_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    tail_d  = tail_q;
    if (cmd_i.take) begin
      if (has_byte_i) begin
        crc_d   = crc_fold;
        count_d = count_inc;
        ovf_d   = ovf_q | count_full;
      end
      if (last_i) begin
        tail_d = has_byte_i ? count_inc : count_q;
      end
    end
    if (cmd_i.tail_step) begin
      crc_d  = crc_fold;
      tail_d = tail_q >> BYTE_W;
    end
    if (cmd_i.emit) begin
      crc_d   = '0;
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  // running state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      tail_q  <= '0;
    end else begin
      crc_q   <= crc_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      tail_q  <= tail_d;
    end
  end

  // result register, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      crc_out_q <= ~crc_q;
      len_out_q <= len_ext;
      ovf_out_q <= ovf_q;
    end
  end

  assign status_o.tail_zero = (tail_q == '0);
  assign crc_value_o        = crc_out_q;
  assign file_length_o      = len_out_q;
  assign length_overflow_o  = ovf_out_q;

endmodule

`default_nettype wire

>>> hdl/pcce_controller.sv
// pcce_controller: stream / length-tail sequencer and result valid flag
// depends on pcce_pkg; commands pcce_datapath
`default_nettype none

module pcce_controller (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_last_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  pcce_pkg::pcce_status_t status_i,
  output pcce_pkg::pcce_cmd_t    cmd_o
);
  import pcce_pkg::*;

  typedef enum logic {
    S_STREAM,
    S_TAIL
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // result register can take a new beat
  assign slot_free = !out_valid_q || out_ready_i;

  // commands
  assign in_ready_o    = (state_q == S_STREAM);
  assign cmd_o.take      = in_valid_i && in_ready_o;
  assign cmd_o.tail_step = (state_q == S_TAIL) && !status_i.tail_zero;
  assign cmd_o.emit      = (state_q == S_TAIL) && status_i.tail_zero && slot_free;

  // next state and result valid
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_STREAM: begin
        if (cmd_o.take && in_last_i) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        if (cmd_o.emit) begin
          state_d     = S_STREAM;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_STREAM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_STREAM;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hdl/pcce_checker.sv
// pcce_checker: port-level assertions for the cksum engine, bound to the top level
// depends on pcce_pkg and posix_cksum_crc32_engine_core
`default_nettype none

module pcce_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_last_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [pcce_pkg::CRC_W-1:0]       out_crc_value_i,
  input logic [pcce_pkg::FILE_LEN_W-1:0]  out_file_length_i
);
  import pcce_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_crc_value_i) && $stable(out_file_length_i))
    else $error("result payload changed while stalled");

  // an accepted end of file closes the input for the tail
  a_tail_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input still open after end of file");

  // a result only appears out of a tail, never while bytes stream
  a_emit_from_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a length tail");

endmodule

bind posix_cksum_crc32_engine_core pcce_checker u_pcce_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_last_i         (in_i.last),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_crc_value_i   (out_o.crc_value),
  .out_file_length_i (out_o.file_length)
);

`default_nettype wire
